>>> design/sha1_pkg.sv
// shared types and constants for the sha-1 hash engine
`timescale 1ns / 1ps
package sha1_pkg;

   localparam int ROUNDS     = 80;
   localparam int ROUND_W    = 7;
   localparam int POS_W      = 6;
   localparam int BLOCK_BITS = 512;

   localparam logic [7:0]     PAD_MARK   = 8'h80;
   localparam logic [POS_W-1:0] LEN_START = 6'd56;
   localparam logic [POS_W-1:0] LAST_POS  = 6'd63;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ROUND  = 5'b00010,
      ST_FINISH = 5'b00100,
      ST_PAD    = 5'b01000,
      ST_OUT    = 5'b10000
   } sha1_state_type;

   typedef enum logic [1:0] {
      SEL_DATA = 2'd0,
      SEL_MARK = 2'd1,
      SEL_ZERO = 2'd2,
      SEL_LEN  = 2'd3
   } sha1_byte_sel_type;

   typedef enum logic [1:0] {
      PH_CH     = 2'd0,
      PH_PARITY = 2'd1,
      PH_MAJ    = 2'd2,
      PH_LAST   = 2'd3
   } sha1_phase_type;

   typedef struct packed {
      logic              shift_en;
      sha1_byte_sel_type byte_sel;
      logic              count_en;
      logic              round_en;
      sha1_phase_type    phase;
      logic              use_msg;
      logic              finish_en;
      logic              init_en;
   } sha1_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
   } sha1_status_type;

endpackage

>>> design/sha1_datapath.sv
// sha-1 datapath: block shift line, round unit, chaining words and bit count
`timescale 1ns / 1ps
module sha1_datapath
   import sha1_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  sha1_cmd_type    cmd,
   input  logic [7:0]      data_byte,
   output sha1_status_type status,
   output logic [31:0]     digest [5]
);

   logic [BLOCK_BITS-1:0] window_ff, window_in;
   logic [63:0]           count_ff, count_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [31:0]           chain_ff [5];
   logic [31:0]           chain_in [5];
   logic [31:0]           work_ff [5];
   logic [31:0]           work_in [5];

   logic [7:0]  byte_val;
   logic [31:0] w0, w2, w8, w13, mix, w_val, f_val, k_val, t_val;
   logic [31:0] a, b, c, d, e;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   assign w0  = window_ff[511:480];
   assign w2  = window_ff[447:416];
   assign w8  = window_ff[255:224];
   assign w13 = window_ff[95:64];
   assign mix = w13 ^ w8 ^ w2 ^ w0;

   always_comb begin
      unique case (cmd.byte_sel)
         SEL_DATA: byte_val = data_byte;
         SEL_MARK: byte_val = PAD_MARK;
         SEL_ZERO: byte_val = 8'h00;
         SEL_LEN:  byte_val = count_ff[{3'd7 - pos_ff[2:0], 3'b000} +: 8];
         default:  byte_val = 8'h00;
      endcase
   end

   always_comb begin
      w_val = cmd.use_msg ? w0 : {mix[30:0], mix[31]};
      unique case (cmd.phase)
         PH_CH: begin
            f_val = (b & c) | (~b & d);
            k_val = K0;
         end
         PH_PARITY: begin
            f_val = b ^ c ^ d;
            k_val = K1;
         end
         PH_MAJ: begin
            f_val = (b & c) | (b & d) | (c & d);
            k_val = K2;
         end
         PH_LAST: begin
            f_val = b ^ c ^ d;
            k_val = K3;
         end
         default: begin
            f_val = b ^ c ^ d;
            k_val = K3;
         end
      endcase
      t_val = {a[26:0], a[31:27]} + f_val + e + k_val + w_val;
   end

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      chain_in  = chain_ff;
      work_in   = work_ff;
      if (cmd.shift_en) begin
         window_in = {window_ff[BLOCK_BITS-9:0], byte_val};
         pos_in    = pos_ff + POS_W'(1);
      end
      if (cmd.count_en) begin
         count_in = count_ff + 64'd8;
      end
      if (cmd.round_en) begin
         window_in  = {window_ff[BLOCK_BITS-33:0], w_val};
         work_in[0] = t_val;
         work_in[1] = a;
         work_in[2] = {b[1:0], b[31:2]};
         work_in[3] = c;
         work_in[4] = d;
      end
      if (cmd.finish_en) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
            work_in[i]  = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.init_en) begin
         count_in   = '0;
         pos_in     = '0;
         chain_in[0] = IV0;
         chain_in[1] = IV1;
         chain_in[2] = IV2;
         chain_in[3] = IV3;
         chain_in[4] = IV4;
         work_in    = chain_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pos_ff     <= '0;
         chain_ff[0] <= IV0;
         chain_ff[1] <= IV1;
         chain_ff[2] <= IV2;
         chain_ff[3] <= IV3;
         chain_ff[4] <= IV4;
         work_ff[0] <= IV0;
         work_ff[1] <= IV1;
         work_ff[2] <= IV2;
         work_ff[3] <= IV3;
         work_ff[4] <= IV4;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         chain_ff <= chain_in;
         work_ff  <= work_in;
      end
   end

   assign status.pos = pos_ff;
   assign digest     = chain_ff;

endmodule

>>> design/sha1_ctrl.sv
// sha-1 controller: word intake, padding sequence, round count and digest handoff
`timescale 1ns / 1ps
module sha1_ctrl
   import sha1_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_byte_valid,
   input  logic            req_end_of_message,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  sha1_status_type status,
   output sha1_cmd_type    cmd
);

   sha1_state_type     state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               pending_ff, pending_in;
   logic               mark_ff, mark_in;
   logic               extra_ff, extra_in;
   logic               accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      pending_in = pending_ff;
      mark_in    = mark_ff;
      extra_in   = extra_ff;

      cmd          = '0;
      cmd.byte_sel = SEL_DATA;
      cmd.use_msg  = (round_ff < ROUND_W'(16));
      if (round_ff < ROUND_W'(20)) begin
         cmd.phase = PH_CH;
      end else if (round_ff < ROUND_W'(40)) begin
         cmd.phase = PH_PARITY;
      end else if (round_ff < ROUND_W'(60)) begin
         cmd.phase = PH_MAJ;
      end else begin
         cmd.phase = PH_LAST;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.shift_en = req_byte_valid;
               cmd.count_en = req_byte_valid;
               if (req_end_of_message) begin
                  pending_in = 1'b1;
                  mark_in    = 1'b1;
               end
               if (req_byte_valid && status.pos == LAST_POS) begin
                  state_in = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.shift_en = 1'b1;
            if (mark_ff) begin
               cmd.byte_sel = SEL_MARK;
               mark_in      = 1'b0;
               extra_in     = (status.pos >= LEN_START);
            end else if (status.pos >= LEN_START && !extra_ff) begin
               cmd.byte_sel = SEL_LEN;
            end else begin
               cmd.byte_sel = SEL_ZERO;
            end
            if (status.pos == LAST_POS) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff == ROUND_W'(ROUNDS - 1)) begin
               round_in = '0;
               state_in = ST_FINISH;
            end else begin
               round_in = round_ff + ROUND_W'(1);
            end
         end
         ST_FINISH: begin
            cmd.finish_en = 1'b1;
            if (!pending_ff) begin
               state_in = ST_IDLE;
            end else if (mark_ff || extra_ff) begin
               extra_in = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               cmd.init_en = 1'b1;
               pending_in  = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         round_ff   <= '0;
         pending_ff <= 1'b0;
         mark_ff    <= 1'b0;
         extra_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         round_ff   <= round_in;
         pending_ff <= pending_in;
         mark_ff    <= mark_in;
         extra_ff   <= extra_in;
      end
   end

endmodule

>>> design/sha1_hash_engine.sv
// sha-1 hash engine top level
// Takes one message word (at most one byte) per accepted request and returns the
// 160-bit digest as five big-endian words after the word that ends the message.
// A word that does not complete a 64-byte block leaves the engine ready for the
// next word. A word that completes a block starts the single round unit, which
// runs one of the 80 rounds per cycle and then folds the result into the chaining
// words before the engine takes the next word. At the end of a message the
// padding bytes and the 64-bit length are shifted in one per cycle up to the end
// of the block, and each of the one or two final blocks is then compressed. The
// digest is held on the response ports until taken; the engine then reinitializes
// and accepts the next message.
`timescale 1ns / 1ps
module sha1_hash_engine
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3,
   output logic [31:0] rsp_digest_word4
);

   sha1_cmd_type    cmd;
   sha1_status_type status;
   logic [31:0]     digest [5];

   sha1_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .status             (status),
      .cmd                (cmd)
   );

   sha1_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_data_byte),
      .status    (status),
      .digest    (digest)
   );

   assign rsp_digest_word0 = digest[0];
   assign rsp_digest_word1 = digest[1];
   assign rsp_digest_word2 = digest[2];
   assign rsp_digest_word3 = digest[3];
   assign rsp_digest_word4 = digest[4];

endmodule
